// File: design/mesh_vertex_normal_engine_top_macros.svh
// Assertion macros for the vertex normal engine.
`ifndef MESH_VERTEX_NORMAL_ENGINE_TOP_MACROS_SVH
`define MESH_VERTEX_NORMAL_ENGINE_TOP_MACROS_SVH
// same-cycle implication, checked on clk, off during reset
`define MVNE_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MVNE_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/mvne_pkg.sv
// Shared constants for the vertex normal engine.
package mvne_pkg;
	localparam int VERT_DEPTH = 1024;
	localparam int IDX_W      = 10;
	localparam int COORD_W    = 16;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int VEC_W      = 35;
	localparam int ACC_W      = 24;
	localparam int NRM_W      = 16;
	localparam int MAG_W      = 32;
	localparam int FRAC_W     = 14;
	localparam int QUO_W      = 15;
	localparam int NUM_W      = MAG_W + FRAC_W + 1;
	localparam int MUL_W      = 33;
	localparam int VROW_W     = 3 * COORD_W;
	localparam int AROW_W     = 3 * ACC_W;
	localparam int SQRT_STEPS = 32;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_TRI   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic signed [ACC_W:0] ACC_MAX = 25'sd8388607;
	localparam logic signed [ACC_W:0] ACC_MIN = -25'sd8388608;
endpackage

// File: design/mvne_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mvne_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: design/mesh_vertex_normal_engine_top.sv
// Top level of the vertex normal engine: sequencer, shared arithmetic, stores.
//
// Usage:
// - Input channel (in_valid / in_stall): one transaction per request. Load
//   writes a vertex, triangle adds its unit face normal to three accumulators,
//   read returns a normalized accumulator, clear zeroes all accumulators.
// - Output channel (out_valid / out_stall): one transaction per read only.
// - Config channel (cfg_valid / cfg_ready / cfg_data): flat_glyph, always
//   ready; when set, triangle transactions are dropped.
// - One request in flight; in_stall is high until it finishes.
// Work is sequenced on the single shared multiplier, the 32-step square
// root and three 15-step restoring divisions on one divider:
// - load: one vertex write; clear: one accumulator row per cycle.
// - read: accumulator read, then normalize; a zero vector skips to the output.
// - triangle: 3 vertex reads, the cross product, normalize, then 3
//   read-modify-write accumulator updates; no update is made when the
//   cross product is zero.
// Reset: a sweep over all 1024 rows zeroes vertex and accumulator stores; the input
// is stalled meanwhile, config writes are still taken.
// A stalled result holds in the output register; the block keeps working
// and only waits if a second read result is ready before the first leaves.
`include "mesh_vertex_normal_engine_top_macros.svh"
module mesh_vertex_normal_engine_top import mvne_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                req_type,
	input  logic [IDX_W-1:0]          vertex_index,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic signed [COORD_W-1:0] pos_z,
	input  logic [IDX_W-1:0]          corner_a,
	input  logic [IDX_W-1:0]          corner_b,
	input  logic [IDX_W-1:0]          corner_c,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [NRM_W-1:0]   normal_x,
	output logic signed [NRM_W-1:0]   normal_y,
	output logic signed [NRM_W-1:0]   normal_z,
	output logic                      zero_length
);
	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_TRD, ST_CROSS, ST_RDACC, ST_NMAX, ST_SQ, ST_SQRT,
		ST_DSET, ST_DIV, ST_DFIN, ST_ACCRD, ST_ACCWR, ST_OUT
	} state_t;

	state_t                   state_q;
	logic                     flat_q;
	logic                     clr_vert_q;
	logic [IDX_W-1:0]         clr_idx_q;
	logic [4:0]               cnt_q;
	logic [1:0]               comp_q;
	logic [1:0]               k_q;
	logic                     is_read_q;
	logic [IDX_W-1:0]         ca_q, cb_q, cc_q;
	logic [VROW_W-1:0]        va_q, vb_q, vc_q;
	logic signed [VEC_W-1:0]  vec_q [3];
	logic signed [2*MUL_W-1:0] prod_q;
	logic [MAG_W-1:0]         rmag_q [3];
	logic                     neg_q [3];
	logic                     zero_q;
	logic [63:0]              sum_q, res_q, bit_q;
	logic [MAG_W:0]           rem_q;
	logic [QUO_W-1:0]         low_q;
	logic signed [NRM_W-1:0]  nrm_q [3];
	logic                     out_valid_q;
	logic signed [NRM_W-1:0]  nx_q, ny_q, nz_q;
	logic                     zl_q;

	// memory ports
	logic              v_we, a_we;
	logic [IDX_W-1:0]  v_waddr, v_raddr, a_waddr, a_raddr;
	logic [VROW_W-1:0] v_wdata, v_rdata;
	logic [AROW_W-1:0] a_wdata, a_rdata;

	logic in_acc;
	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	function automatic logic signed [EDGE_W-1:0] edge_of(logic [COORD_W-1:0] b,
			logic [COORD_W-1:0] a);
		return $signed({b[COORD_W-1], b}) - $signed({a[COORD_W-1], a});
	endfunction

	function automatic logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] a,
			logic signed [NRM_W-1:0] n);
		logic signed [ACC_W:0] t;
		t = $signed({a[ACC_W-1], a}) + $signed({{(ACC_W+1-NRM_W){n[NRM_W-1]}}, n});
		if (t > ACC_MAX) t = ACC_MAX;
		if (t < ACC_MIN) t = ACC_MIN;
		return t[ACC_W-1:0];
	endfunction

	// edges b-a and c-a, from the latched corners
	logic signed [EDGE_W-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
	assign e1x = edge_of(vb_q[COORD_W-1:0], va_q[COORD_W-1:0]);
	assign e1y = edge_of(vb_q[2*COORD_W-1:COORD_W], va_q[2*COORD_W-1:COORD_W]);
	assign e1z = edge_of(vb_q[3*COORD_W-1:2*COORD_W], va_q[3*COORD_W-1:2*COORD_W]);
	assign e2x = edge_of(vc_q[COORD_W-1:0], va_q[COORD_W-1:0]);
	assign e2y = edge_of(vc_q[2*COORD_W-1:COORD_W], va_q[2*COORD_W-1:COORD_W]);
	assign e2z = edge_of(vc_q[3*COORD_W-1:2*COORD_W], va_q[3*COORD_W-1:2*COORD_W]);

	// shared multiplier: cross-product terms, then squares of magnitudes
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SQ) begin
			mul_a = $signed({1'b0, rmag_q[cnt_q[1:0]]});
			mul_b = $signed({1'b0, rmag_q[cnt_q[1:0]]});
		end else begin
			case (cnt_q[2:0])
				3'd0: begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2z); end
				3'd1: begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2y); end
				3'd2: begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2x); end
				3'd3: begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2z); end
				3'd4: begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2y); end
				3'd5: begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2x); end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
		mul_p = mul_a * mul_b;
	end

	logic [2:0] cj;
	assign cj = cnt_q[2:0] - 3'd1;

	// range reduction: shift so the largest magnitude is below 2^31
	logic [VEC_W-1:0]        absv [3];
	logic [VEC_W-1:0]        mmax;
	logic [2:0]              shamt;
	logic signed [VEC_W-1:0] shv [3];
	logic [VEC_W-1:0]        shabs [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			absv[i] = vec_q[i][VEC_W-1] ? VEC_W'(-vec_q[i]) : VEC_W'(vec_q[i]);
		end
		mmax = absv[0];
		if (absv[1] > mmax) mmax = absv[1];
		if (absv[2] > mmax) mmax = absv[2];
		if (mmax[34])      shamt = 3'd4;
		else if (mmax[33]) shamt = 3'd3;
		else if (mmax[32]) shamt = 3'd2;
		else if (mmax[31]) shamt = 3'd1;
		else               shamt = 3'd0;
		for (int i = 0; i < 3; i++) begin
			shv[i]   = vec_q[i] >>> shamt;
			shabs[i] = shv[i][VEC_W-1] ? VEC_W'(-shv[i]) : VEC_W'(shv[i]);
		end
	end

	// square root step
	logic [63:0] sq_t;
	assign sq_t = res_q + bit_q;

	// divider setup and step
	logic [NUM_W-1:0] num;
	logic [MAG_W:0]   dv_t;
	logic             dv_ge;
	assign num   = {1'b0, rmag_q[comp_q], FRAC_W'(0)} + NUM_W'(res_q[MAG_W-1:1]);
	assign dv_t  = {rem_q[MAG_W-1:0], low_q[QUO_W-1]};
	assign dv_ge = (dv_t >= {1'b0, res_q[MAG_W-1:0]});

	logic [IDX_W-1:0] corner_k;
	always_comb begin
		case (k_q)
			2'd0:    corner_k = ca_q;
			2'd1:    corner_k = cb_q;
			default: corner_k = cc_q;
		endcase
	end

	// memory port muxing
	always_comb begin
		v_we    = 1'b0;
		v_waddr = vertex_index;
		v_wdata = {pos_z, pos_y, pos_x};
		v_raddr = corner_a;
		a_we    = 1'b0;
		a_waddr = corner_k;
		a_wdata = {sat_add(a_rdata[3*ACC_W-1:2*ACC_W], nrm_q[2]),
			sat_add(a_rdata[2*ACC_W-1:ACC_W], nrm_q[1]),
			sat_add(a_rdata[ACC_W-1:0], nrm_q[0])};
		a_raddr = vertex_index;
		case (state_q)
			ST_CLR: begin
				v_we    = clr_vert_q;
				v_waddr = clr_idx_q;
				v_wdata = '0;
				a_we    = 1'b1;
				a_waddr = clr_idx_q;
				a_wdata = '0;
			end
			ST_IDLE: begin
				v_we = in_acc && (req_type == REQ_LOAD);
			end
			ST_TRD: begin
				v_raddr = (cnt_q[1:0] == 2'd0) ? cb_q : cc_q;
			end
			ST_ACCRD: begin
				a_raddr = corner_k;
			end
			ST_ACCWR: begin
				a_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	mvne_ram #(.WIDTH(VROW_W), .DEPTH(VERT_DEPTH)) u_vert_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	mvne_ram #(.WIDTH(AROW_W), .DEPTH(VERT_DEPTH)) u_acc_ram (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr(a_raddr), .rdata(a_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			flat_q      <= 1'b0;
			clr_vert_q  <= 1'b1;
			clr_idx_q   <= '0;
			cnt_q       <= '0;
			comp_q      <= '0;
			k_q         <= '0;
			is_read_q   <= 1'b0;
			zero_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				flat_q <= cfg_data;
			end
			// the output state reloads the register itself
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == IDX_W'(VERT_DEPTH - 1)) begin
						clr_vert_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					ca_q <= corner_a;
					cb_q <= corner_b;
					cc_q <= corner_c;
					cnt_q <= '0;
					if (in_acc) begin
						case (req_type)
							REQ_TRI: begin
								is_read_q <= 1'b0;
								if (!flat_q) state_q <= ST_TRD;
							end
							REQ_READ: begin
								is_read_q <= 1'b1;
								state_q   <= ST_RDACC;
							end
							REQ_CLEAR: begin
								clr_idx_q <= '0;
								state_q   <= ST_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				ST_TRD: begin
					case (cnt_q[1:0])
						2'd0:    va_q <= v_rdata;
						2'd1:    vb_q <= v_rdata;
						default: vc_q <= v_rdata;
					endcase
					if (cnt_q[1:0] == 2'd2) begin
						cnt_q   <= '0;
						state_q <= ST_CROSS;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CROSS: begin
					cnt_q  <= cnt_q + 1'b1;
					prod_q <= mul_p;
					if (cnt_q != '0) begin
						if (!cj[0]) vec_q[cj[2:1]] <= prod_q[VEC_W-1:0];
						else        vec_q[cj[2:1]] <= vec_q[cj[2:1]] - prod_q[VEC_W-1:0];
					end
					if (cnt_q == 5'd6) state_q <= ST_NMAX;
				end
				ST_RDACC: begin
					vec_q[0] <= VEC_W'($signed(a_rdata[ACC_W-1:0]));
					vec_q[1] <= VEC_W'($signed(a_rdata[2*ACC_W-1:ACC_W]));
					vec_q[2] <= VEC_W'($signed(a_rdata[3*ACC_W-1:2*ACC_W]));
					state_q  <= ST_NMAX;
				end
				ST_NMAX: begin
					for (int i = 0; i < 3; i++) begin
						rmag_q[i] <= shabs[i][MAG_W-1:0];
						neg_q[i]  <= shv[i][VEC_W-1];
						nrm_q[i]  <= '0;
					end
					cnt_q  <= '0;
					comp_q <= '0;
					k_q    <= '0;
					zero_q <= (mmax == '0);
					if (mmax == '0) state_q <= is_read_q ? ST_OUT : ST_IDLE;
					else            state_q <= ST_SQ;
				end
				ST_SQ: begin
					prod_q <= mul_p;
					if (cnt_q == 5'd1)      sum_q <= prod_q[63:0];
					else if (cnt_q != '0)   sum_q <= sum_q + prod_q[63:0];
					if (cnt_q == 5'd3) begin
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					bit_q <= bit_q >> 2;
					if (sum_q >= sq_t) begin
						sum_q <= sum_q - sq_t;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					if (cnt_q == 5'(SQRT_STEPS - 1)) state_q <= ST_DSET;
				end
				ST_DSET: begin
					rem_q   <= {1'b0, num[NUM_W-1:QUO_W]};
					low_q   <= num[QUO_W-1:0];
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					rem_q <= dv_ge ? (dv_t - {1'b0, res_q[MAG_W-1:0]}) : dv_t;
					low_q <= {low_q[QUO_W-2:0], dv_ge};
					if (cnt_q == 5'(QUO_W - 1)) state_q <= ST_DFIN;
				end
				ST_DFIN: begin
					nrm_q[comp_q] <= neg_q[comp_q] ? -$signed({1'b0, low_q})
						: $signed({1'b0, low_q});
					comp_q <= comp_q + 1'b1;
					if (comp_q == 2'd2) state_q <= is_read_q ? ST_OUT : ST_ACCRD;
					else                state_q <= ST_DSET;
				end
				ST_ACCRD: begin
					state_q <= ST_ACCWR;
				end
				ST_ACCWR: begin
					k_q <= k_q + 1'b1;
					state_q <= (k_q == 2'd2) ? ST_IDLE : ST_ACCRD;
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						nx_q        <= nrm_q[0];
						ny_q        <= nrm_q[1];
						nz_q        <= nrm_q[2];
						zl_q        <= zero_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign normal_x    = nx_q;
	assign normal_y    = ny_q;
	assign normal_z    = nz_q;
	assign zero_length = zl_q;

	logic nrm0_ok;
	assign nrm0_ok = (nrm_q[0] <= 16'sd16384) && (nrm_q[0] >= -16'sd16384);

	`MVNE_ASSERT_IMP(a_out_from_seq, $rose(out_valid_q), $past(state_q) == ST_OUT, "stray result")
	`MVNE_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, res_q[MAG_W-1:0] != '0, "divide by zero length")
	`MVNE_ASSERT_IMP(a_acc_nonzero, state_q == ST_ACCWR, !zero_q, "zero normal accumulated")
	`MVNE_ASSERT_NXT(a_norm_range, state_q == ST_DFIN, nrm0_ok, "normal out of range")
endmodule

// File: tb/mesh_vertex_normal_engine_top_tb.sv
// Testbench for the vertex normal engine: directed and random requests checked against a predictor.
module mesh_vertex_normal_engine_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mvne_pkg::*;

	localparam longint CYCLE_LIMIT = 1500000;
	// worst quiet time after the last read: a full accumulator clear sweep
	localparam int SETTLE_CYCLES = 1200;

	typedef longint vec3_t [3];
	typedef struct {
		logic signed [NRM_W-1:0] nx;
		logic signed [NRM_W-1:0] ny;
		logic signed [NRM_W-1:0] nz;
		logic                    zl;
	} normal_t;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready, cfg_data;
	logic in_valid, in_stall;
	logic [1:0] req_type;
	logic [IDX_W-1:0] vertex_index, corner_a, corner_b, corner_c;
	logic signed [COORD_W-1:0] pos_x, pos_y, pos_z;
	logic out_valid, out_stall;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
	logic zero_length;

	mesh_vertex_normal_engine_top dut (.*);

	// predictor state: vertex positions, accumulators, flat flag
	longint vert_x [VERT_DEPTH];
	longint vert_y [VERT_DEPTH];
	longint vert_z [VERT_DEPTH];
	longint sum_x [VERT_DEPTH];
	longint sum_y [VERT_DEPTH];
	longint sum_z [VERT_DEPTH];
	bit flat_mode;

	normal_t pending_normals [$];
	int errors, n_sent, n_checked, n_tri, n_clear, n_zero_len;
	longint cycles;
	bit hold_req;
	int pool [12];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TIMEOUT at %0t", $realtime);
			$display("mesh_vertex_normal_engine_top verification failed");
			$finish;
		end
	end

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned absval(input longint v);
		return v < 0 ? longint'(-v) : v;
	endfunction

	// scale to Q1.14 unit length; returns 0 for the zero vector
	function automatic bit unit_vector(input vec3_t v, output vec3_t n);
		longint unsigned m, sq, len, q;
		longint r [3];
		int sh;
		m = absval(v[0]);
		if (absval(v[1]) > m) m = absval(v[1]);
		if (absval(v[2]) > m) m = absval(v[2]);
		n = '{0, 0, 0};
		if (m == 0) return 0;
		sh = 0;
		while ((m >> sh) >= (64'd1 << 31)) sh++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			r[i] = v[i] >>> sh;
			sq += absval(r[i]) * absval(r[i]);
		end
		len = floor_sqrt(sq);
		for (int i = 0; i < 3; i++) begin
			q = (absval(r[i]) * 16384 + len / 2) / len;
			n[i] = r[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint sat_acc(input longint a);
		if (a > ACC_MAX) return ACC_MAX;
		if (a < ACC_MIN) return ACC_MIN;
		return a;
	endfunction

	// apply one accepted request to the model, queue any read result
	function automatic void predict_request(input logic [1:0] rt, input int vi,
			input longint px, input longint py, input longint pz, input int ca,
			input int cb, input int cc);
		vec3_t cr, n;
		longint e1 [3], e2 [3];
		int corners [3];
		normal_t exp_n;
		bit ok;
		case (rt)
			REQ_LOAD: begin
				// positions as the port carries them: 16-bit two's complement
				vert_x[vi] = longint'($signed(px[COORD_W-1:0]));
				vert_y[vi] = longint'($signed(py[COORD_W-1:0]));
				vert_z[vi] = longint'($signed(pz[COORD_W-1:0]));
			end
			REQ_TRI: begin
				if (!flat_mode) begin
					e1 = '{vert_x[cb] - vert_x[ca], vert_y[cb] - vert_y[ca],
						vert_z[cb] - vert_z[ca]};
					e2 = '{vert_x[cc] - vert_x[ca], vert_y[cc] - vert_y[ca],
						vert_z[cc] - vert_z[ca]};
					cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
					cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
					cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
					ok = unit_vector(cr, n);
					corners = '{ca, cb, cc};
					// repeated corners get the normal once per mention
					foreach (corners[k]) begin
						sum_x[corners[k]] = sat_acc(sum_x[corners[k]] + n[0]);
						sum_y[corners[k]] = sat_acc(sum_y[corners[k]] + n[1]);
						sum_z[corners[k]] = sat_acc(sum_z[corners[k]] + n[2]);
					end
				end
			end
			REQ_CLEAR: begin
				foreach (sum_x[k]) begin
					sum_x[k] = 0; sum_y[k] = 0; sum_z[k] = 0;
				end
			end
			default: begin
				cr = '{sum_x[vi], sum_y[vi], sum_z[vi]};
				ok = unit_vector(cr, n);
				exp_n.nx = NRM_W'(n[0]);
				exp_n.ny = NRM_W'(n[1]);
				exp_n.nz = NRM_W'(n[2]);
				exp_n.zl = !ok;
				pending_normals = {pending_normals, exp_n};
			end
		endcase
	endfunction

	// one input transaction, with a random gap in front
	task automatic send_req(input logic [1:0] rt, input int vi, input longint px,
			input longint py, input longint pz, input int ca, input int cb, input int cc);
		int gap;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= rt;
		vertex_index <= IDX_W'(vi);
		pos_x <= COORD_W'(px); pos_y <= COORD_W'(py); pos_z <= COORD_W'(pz);
		corner_a <= IDX_W'(ca); corner_b <= IDX_W'(cb); corner_c <= IDX_W'(cc);
		do @(posedge clk); while (in_stall);
		predict_request(rt, vi, px, py, pz, ca, cb, cc);
		n_sent++;
		if (rt == REQ_TRI) n_tri++;
		if (rt == REQ_CLEAR) n_clear++;
	endtask

	task automatic load_vertex(input int vi, input longint px, input longint py,
			input longint pz);
		send_req(REQ_LOAD, vi, px, py, pz, $urandom_range(0, 1023),
			$urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	task automatic add_tri(input int ca, input int cb, input int cc);
		send_req(REQ_TRI, $urandom_range(0, 1023), $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
			ca, cb, cc);
	endtask

	task automatic read_normal(input int vi);
		send_req(REQ_READ, vi, $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	task automatic clear_all();
		send_req(REQ_CLEAR, $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0);
	endtask

	// wait for every read result, then for clears/triangles still running
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_flat(input bit v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		flat_mode = v;
	endtask

	// extremes of the position range, degenerate and repeated-corner triangles
	task automatic test_directed();
		read_normal(5);
		load_vertex(1023, 32767, -32768, 32767);
		load_vertex(1, -32768, 32767, -32768);
		load_vertex(2, 0, 0, 0);
		load_vertex(0, -1, -1, -1);
		add_tri(2, 1023, 1);
		add_tri(1, 1, 2);
		add_tri(0, 2, 1023);
		load_vertex(3, 16384, 16384, 16384);
		add_tri(2, 0, 3);
		read_normal(1023);
		read_normal(1);
		read_normal(2);
		read_normal(0);
		read_normal(3);
		clear_all();
		read_normal(1023);
		read_normal(0);
	endtask

	// flat glyph drops triangles; reads and clears still act
	task automatic test_flat_glyph();
		write_flat(1'b1);
		add_tri(2, 1023, 1);
		read_normal(2);
		load_vertex(4, 100, -200, 300);
		add_tri(4, 1, 1023);
		read_normal(4);
		clear_all();
		write_flat(1'b0);
		add_tri(4, 1, 1023);
		read_normal(4);
	endtask

	// one axis-aligned face added until the accumulator pins at its maximum
	task automatic test_saturation();
		load_vertex(10, 0, 0, 0);
		load_vertex(11, 16384, 0, 0);
		load_vertex(12, 0, 16384, 0);
		for (int i = 0; i < 520; i++) begin
			add_tri(10, 11, 12);
			if (i % 128 == 127) read_normal(11);
		end
		read_normal(10);
		read_normal(12);
		add_tri(12, 11, 10);
		read_normal(10);
	endtask

	// receiver holds off long enough that the input stalls; then a full drain
	task automatic test_backpressure();
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++) read_normal(pool[i]);
		drain();
		for (int i = 0; i < 4; i++) read_normal(pool[i]);
	endtask

	task automatic test_random(input int count);
		int sel, cfg_step;
		cfg_step = 0;
		foreach (pool[k]) load_vertex(pool[k], $urandom_range(0, 65535) - 32768,
			$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
		for (int i = 0; i < count; i++) begin
			if (i % 140 == 139) begin
				cfg_step++;
				write_flat(cfg_step % 3 == 1);
			end
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				if ($urandom_range(0, 3) == 0)
					load_vertex(pool[$urandom_range(0, 11)], $urandom_range(0, 7) - 4,
						$urandom_range(0, 7) - 4, $urandom_range(0, 7) - 4);
				else
					load_vertex($urandom_range(0, 9) == 0 ? $urandom_range(0, 1023)
						: pool[$urandom_range(0, 11)], $urandom_range(0, 65535) - 32768,
						$urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
			end else if (sel < 70) begin
				if ($urandom_range(0, 9) == 0)
					add_tri($urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023));
				else
					add_tri(pool[$urandom_range(0, 11)], pool[$urandom_range(0, 11)],
						pool[$urandom_range(0, 11)]);
			end else if (sel < 98) begin
				read_normal($urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
					: pool[$urandom_range(0, 11)]);
			end else begin
				clear_all();
			end
		end
	endtask

	// result checker with random stalls and one long hold-off
	initial begin
		normal_t exp_n;
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				n = $urandom_range(0, 18);
				if ($urandom_range(0, 3) == 0) n = 0;
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			n_checked++;
			if (pending_normals.size() == 0) begin
				errors++;
				$display("%0t unexpected result: %0d %0d %0d zl=%0b", $realtime,
					normal_x, normal_y, normal_z, zero_length);
			end else begin
				exp_n = pending_normals.pop_front();
				if (exp_n.zl) n_zero_len++;
				if (normal_x !== exp_n.nx || normal_y !== exp_n.ny ||
						normal_z !== exp_n.nz || zero_length !== exp_n.zl) begin
					errors++;
					$display("%0t mismatch: expected %0d %0d %0d zl=%0b, got %0d %0d %0d zl=%0b",
						$realtime, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.zl,
						normal_x, normal_y, normal_z, zero_length);
				end
			end
		end
	end

	initial begin
		cycles = 0; errors = 0; n_sent = 0; n_checked = 0; n_tri = 0;
		n_clear = 0; n_zero_len = 0; hold_req = 0; flat_mode = 0;
		arst_n = 0; cfg_valid = 0; cfg_data = 0; in_valid = 0; out_stall = 0;
		req_type = REQ_LOAD; vertex_index = 0; pos_x = 0; pos_y = 0; pos_z = 0;
		corner_a = 0; corner_b = 0; corner_c = 0;
		foreach (vert_x[k]) begin
			vert_x[k] = 0; vert_y[k] = 0; vert_z[k] = 0;
			sum_x[k] = 0; sum_y[k] = 0; sum_z[k] = 0;
		end
		foreach (pool[k]) pool[k] = $urandom_range(0, 1023);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_flat(1'b0);
		test_directed();
		test_flat_glyph();
		test_saturation();
		test_backpressure();
		test_random(650);
		drain();
		$display("Covered %0d requests (%0d triangles, %0d clears), %0d normals checked,",
			n_sent, n_tri, n_clear, n_checked);
		$display("  %0d of them zero length, with flat mode toggled and long output stalls.",
			n_zero_len);
		if (errors == 0 && pending_normals.size() == 0)
			$display("mesh_vertex_normal_engine_top verification clean");
		else
			$display("mesh_vertex_normal_engine_top verification failed");
		$finish;
	end
endmodule
